// File: src/mshash_pkg.sv
// shared types and constants for the string hash block
`timescale 1ns / 1ps

package mshash_pkg;

    // hash constants
    localparam logic [31:0] HASH_INIT = 32'hDEAD_BEEF;
    localparam logic [31:0] HASH_MUL  = 32'h7FD6_52AD;

    // xorshift amounts
    localparam logic [4:0] SHIFT_WORD = 5'd16;
    localparam logic [4:0] SHIFT_FIN1 = 5'd10;
    localparam logic [4:0] SHIFT_FIN2 = 5'd17;

    // ascii case folding
    localparam logic [7:0] LOWER_BELOW = 8'h60;
    localparam logic [7:0] LOWER_ABOVE = 8'h7B;
    localparam logic [7:0] CASE_DELTA  = 8'h20;

    // configuration register indexes
    localparam logic [1:0] CFG_SEED       = 2'd0;
    localparam logic [1:0] CFG_BIG_ENDIAN = 2'd1;
    localparam logic [1:0] CFG_FOLD_CASE  = 2'd2;

    // shared unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_MUL,
        ALU_XSH
    } t_alu_op;

    // control bundle for the shared unit
    typedef struct packed {
        t_alu_op    op;
        logic [4:0] shamt;
    } t_alu_ctl;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_MUL,
        S_XS,
        S_FMUL1,
        S_FXS1,
        S_FMUL2,
        S_FXS2
    } t_state;

endpackage

// File: src/mshash_alu.sv
// shared add / constant multiply / xorshift unit
`timescale 1ns / 1ps

module mshash_alu (
    input  mshash_pkg::t_alu_ctl i_ctl,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    output logic [31:0]          o_y
);
    import mshash_pkg::*;

    logic [31:0] w_prod;

    // low word of the product is all that matters
    assign w_prod = i_a * HASH_MUL;

    // operation select
    always_comb begin
        case (i_ctl.op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_MUL: o_y = w_prod;
            ALU_XSH: o_y = i_a ^ (i_a >> i_ctl.shamt);
            default: o_y = i_a;
        endcase
    end

endmodule

// File: src/murmur_style_string_hash_top.sv
// top level of the string hash block: config, input capture, sequencer
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_data_word, i_byte_count, i_last
//  out     | from block| o_out_valid / i_out_stall | o_hash_value
//  cfg     | to block  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  a word goes through capture, add, multiply and xorshift steps in the one
//  shared unit; a final item then adds the finalize multiply and xorshift steps.
//  an empty final item skips straight to the finalize steps.
//  the output register frees the input side: the next transaction is taken while
//  a result waits; finalizing holds only if a prior result is still stalled.
//  reset is synchronous, active low, and loads the accumulator with 0xDEADBEEF.
`timescale 1ns / 1ps

module murmur_style_string_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);
    import mshash_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_init;
    logic        r_big_endian;
    logic        r_fold_case;
    logic [31:0] r_acc;
    logic [31:0] r_word;
    logic        r_last;
    logic        r_out_valid;
    logic [31:0] r_hash;

    t_alu_ctl    w_ctl;
    logic [31:0] w_alu_y;
    logic        w_acc_load;
    logic        w_in_accept;
    logic        w_out_free;
    logic [7:0]  w_byte [4];
    logic [31:0] w_capture;
    logic        w_full;
    logic        w_empty;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hash_value = r_hash;

    // per-byte case folding
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_byte[k] = i_data_word[8*k +: 8];
            if (r_fold_case && w_byte[k] > LOWER_BELOW && w_byte[k] < LOWER_ABOVE) begin
                w_byte[k] = w_byte[k] - CASE_DELTA;
            end
        end
    end

    // word or tail formation
    assign w_full  = i_byte_count[2];
    assign w_empty = (i_byte_count == 3'd0);
    always_comb begin
        if (w_full) begin
            if (r_big_endian) begin
                w_capture = {w_byte[0], w_byte[1], w_byte[2], w_byte[3]};
            end else begin
                w_capture = {w_byte[3], w_byte[2], w_byte[1], w_byte[0]};
            end
        end else begin
            case (i_byte_count[1:0])
                2'd1:    w_capture = {24'd0, w_byte[0]};
                2'd2:    w_capture = {16'd0, w_byte[1], w_byte[0]};
                2'd3:    w_capture = {8'd0, w_byte[2], w_byte[1], w_byte[0]};
                default: w_capture = 32'd0;
            endcase
        end
    end

    // shared arithmetic unit
    mshash_alu u_alu (
        .i_ctl (w_ctl),
        .i_a   (r_acc),
        .i_b   (r_word),
        .o_y   (w_alu_y)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = (w_full || !w_empty) ? S_ADD : S_FMUL1;
                end
            end
            S_ADD:   n_state = S_MUL;
            S_MUL:   n_state = S_XS;
            S_XS:    n_state = r_last ? S_FMUL1 : S_IDLE;
            S_FMUL1: n_state = S_FXS1;
            S_FXS1:  n_state = S_FMUL2;
            S_FMUL2: n_state = S_FXS2;
            S_FXS2:  n_state = w_out_free ? S_IDLE : S_FXS2;
            default: n_state = S_IDLE;
        endcase
    end

    // unit controls per state
    always_comb begin
        w_ctl.op    = ALU_ADD;
        w_ctl.shamt = SHIFT_WORD;
        w_acc_load  = 1'b0;
        case (r_state)
            S_ADD: begin
                w_ctl.op   = ALU_ADD;
                w_acc_load = 1'b1;
            end
            S_MUL, S_FMUL1, S_FMUL2: begin
                w_ctl.op   = ALU_MUL;
                w_acc_load = 1'b1;
            end
            S_XS: begin
                w_ctl.op   = ALU_XSH;
                w_acc_load = 1'b1;
            end
            S_FXS1: begin
                w_ctl.op    = ALU_XSH;
                w_ctl.shamt = SHIFT_FIN1;
                w_acc_load  = 1'b1;
            end
            S_FXS2: begin
                w_ctl.op    = ALU_XSH;
                w_ctl.shamt = SHIFT_FIN2;
            end
            default: begin
                w_ctl.op = ALU_ADD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_init       <= HASH_INIT;
            r_big_endian <= 1'b0;
            r_fold_case  <= 1'b0;
            r_acc        <= HASH_INIT;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SEED: begin
                        r_init <= i_cfg_data + HASH_INIT;
                        r_acc  <= i_cfg_data + HASH_INIT;
                    end
                    CFG_BIG_ENDIAN: r_big_endian <= i_cfg_data[0];
                    CFG_FOLD_CASE:  r_fold_case  <= i_cfg_data[0];
                    default: ;
                endcase
            end else if (w_acc_load) begin
                r_acc <= w_alu_y;
            end else if (r_state == S_FXS2 && w_out_free) begin
                r_acc <= r_init;
            end
            // output register
            if (r_state == S_FXS2 && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_word <= w_capture;
            r_last <= i_last || !w_full;
        end
        if (r_state == S_FXS2 && w_out_free) begin
            r_hash <= w_alu_y;
        end
    end

`ifndef SYNTHESIS
    // an accepted transaction makes the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> o_in_stall)
        else $error("block not busy after accepting a transaction");

    // an empty item goes straight to finalization
    a_empty_to_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_byte_count == 3'd0) |=> (r_state == S_FMUL1))
        else $error("empty item did not go to finalization");

    // delivering a result reloads the accumulator
    a_reload_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FXS2 && w_out_free && !i_cfg_we) |=> (r_acc == r_init && r_out_valid))
        else $error("accumulator not reloaded after result");

    // a seed write reloads the accumulator
    a_seed_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == CFG_SEED)
        |=> (r_acc == $past(i_cfg_data) + HASH_INIT))
        else $error("seed write did not reload the accumulator");
`endif

endmodule
